// ===== hw/rtl/sust_pkg.sv =====
package sust_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int MODE_W     = 2;
    localparam int IN_VALUE_W = 32;
    localparam int RIDX_W     = 6;
    localparam int IDX_W      = 7;
    localparam int STATUS_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // Reply index for "absent": all ones, i.e. -1
    localparam logic [IDX_W-1:0] NO_INDEX = '1;

    // Row-wide shift commands, broadcast to every cell
    typedef struct packed {
        logic insert_go;
        logic delete_go;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/sust_cell.sv =====
module sust_cell import sust_pkg::*; #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CNT_W       = 7
) (
    input  logic                   i_clk,
    input  logic                   i_capture,
    input  logic [VALUE_WIDTH-1:0] i_probe_value,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [RIDX_W-1:0]      i_read_index,
    input  t_cell_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_ins_value,
    input  logic [VALUE_WIDTH-1:0] i_left_value,
    input  logic [VALUE_WIDTH-1:0] i_right_value,
    input  logic                   i_left_lt,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_lt,
    output logic                   o_eq,
    output logic                   o_sel
);

    localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam bit IN_READ_RANGE = (INDEX < (1 << RIDX_W));

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_lt;
    logic                   r_eq;
    logic                   r_sel;
    logic                   w_valid;
    logic [VALUE_WIDTH-1:0] w_key_own;
    logic [VALUE_WIDTH-1:0] w_key_probe;

    assign w_valid     = (CNT_W'(INDEX) < i_count);
    // sign flip: unsigned compare of keys gives signed order
    assign w_key_own   = r_value ^ SIGN;
    assign w_key_probe = i_probe_value ^ SIGN;

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_lt  <= w_valid && (w_key_own < w_key_probe);
            r_eq  <= w_valid && (w_key_own == w_key_probe);
            r_sel <= IN_READ_RANGE && w_valid && (i_read_index == RIDX_W'(INDEX));
        end
        // cells at or above the insertion point move
        if (i_ctrl.insert_go && !r_lt) begin
            r_value <= i_left_lt ? i_ins_value : i_left_value;
        end else if (i_ctrl.delete_go && !r_lt) begin
            r_value <= i_right_value;
        end
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_sel   = r_sel;

endmodule

// ===== hw/rtl/sorted_unique_set_table.sv =====
// The cell row compares as the input word is accepted and shifts when S_EXEC
// commits, which also registers the result word; a new word waits for that
// shift to land, so the block holds one word in work at a time.
// A waiting result does not block accept; the shift cycle stalls until it is taken.
// Reset (sync, active low) clears the entry count and handshake state; the cell
// values stay undefined until written and are never read at or above the count.
module sorted_unique_set_table import sust_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [MODE_W-1:0]            i_mode,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    input  logic [RIDX_W-1:0]            i_read_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [IDX_W-1:0]      o_found_index,
    output logic [IDX_W-1:0]             o_entry_count,
    output logic signed [IN_VALUE_W-1:0] o_read_value,
    output logic [STATUS_W-1:0]          o_status
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // control
    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // captured word
    t_mode                  r_mode;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [RIDX_W-1:0]      r_ridx;

    // result register
    logic [IDX_W-1:0]      r_found;
    logic [IDX_W-1:0]      r_count_o;
    logic [IN_VALUE_W-1:0] r_rval;
    t_status               r_status;
    logic [IDX_W-1:0]      n_found;
    logic [IN_VALUE_W-1:0] n_rval;
    t_status               n_status;

    // cell row
    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]    w_lt;
    logic [CAPACITY-1:0]    w_eq;
    logic [CAPACITY-1:0]    w_sel;
    logic [CAPACITY-1:0]    w_bound;
    logic [VALUE_WIDTH-1:0] w_probe;
    t_cell_ctrl             w_ctrl;

    logic                   w_capture;
    logic                   w_fire;
    logic                   w_hit;
    logic                   w_rd_ok;
    logic                   w_full;
    logic [IW-1:0]          w_pos;
    logic [VALUE_WIDTH-1:0] w_rd_entry;
    logic [IN_VALUE_W-1:0]  w_rd_word;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_capture  = i_in_valid && o_in_ready;
    // shift/commit cycle, held off while the result register is still occupied
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Only the low VALUE_WIDTH bits of the word take part; a wider table
    // holds the 32-bit word zero-extended.
    generate
        if (VALUE_WIDTH <= IN_VALUE_W) begin : g_probe_narrow
            assign w_probe = i_value[VALUE_WIDTH-1:0];
        end else begin : g_probe_wide
            assign w_probe = {{(VALUE_WIDTH-IN_VALUE_W){1'b0}}, i_value};
        end
    endgenerate

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_left_val;
            logic [VALUE_WIDTH-1:0] w_right_val;
            logic                   w_left_lt;

            if (g == 0) begin : g_head
                // cell 0 always sits on the boundary when it does not compare low
                assign w_left_val = '0;
                assign w_left_lt  = 1'b1;
            end else begin : g_body
                assign w_left_val = w_val[g-1];
                assign w_left_lt  = w_lt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_val = w_val[g];
            end else begin : g_inner
                assign w_right_val = w_val[g+1];
            end

            sust_cell #(
                .INDEX       (g),
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_capture     (w_capture),
                .i_probe_value (w_probe),
                .i_count       (r_count),
                .i_read_index  (i_read_index),
                .i_ctrl        (w_ctrl),
                .i_ins_value   (r_value),
                .i_left_value  (w_left_val),
                .i_right_value (w_right_val),
                .i_left_lt     (w_left_lt),
                .o_value       (w_val[g]),
                .o_lt          (w_lt[g]),
                .o_eq          (w_eq[g]),
                .o_sel         (w_sel[g])
            );
        end
    endgenerate

    // lt flags form a thermometer; the first cell not below the probe is the
    // insertion point. All-ones means the point is past the last cell.
    assign w_bound = ~w_lt & {w_lt[CAPACITY-2:0], 1'b1};
    assign w_hit   = |w_eq;
    assign w_rd_ok = |w_sel;
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_pos      = '0;
        w_rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_bound[i]) begin
                w_pos = w_pos | IW'(i);
            end
            if (w_sel[i]) begin
                w_rd_entry = w_rd_entry | w_val[i];
            end
        end
    end

    // entries are returned zero-extended or truncated to the 32-bit port
    generate
        if (VALUE_WIDTH >= IN_VALUE_W) begin : g_rd_trunc
            assign w_rd_word = w_rd_entry[IN_VALUE_W-1:0];
        end else begin : g_rd_ext
            assign w_rd_word = {{(IN_VALUE_W-VALUE_WIDTH){1'b0}}, w_rd_entry};
        end
    endgenerate

    // result and shift decode
    always_comb begin
        n_found = NO_INDEX;
        n_rval  = '0;
        n_status = ST_DONE;
        n_count = r_count;
        w_ctrl  = '0;
        case (r_mode)
            MODE_INSERT: begin
                if (w_hit) begin
                    n_found = IDX_W'(w_pos);
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_found          = IDX_W'(w_pos);
                    n_count          = r_count + CNT_W'(1);
                    w_ctrl.insert_go = w_fire;
                end
            end
            MODE_SEARCH: begin
                if (w_hit) begin
                    n_found = IDX_W'(w_pos);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_DELETE: begin
                if (w_hit) begin
                    n_found          = IDX_W'(w_pos);
                    n_count          = r_count - CNT_W'(1);
                    w_ctrl.delete_go = w_fire;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (w_rd_ok) begin
                    n_found = IDX_W'(r_ridx);
                    n_rval  = w_rd_word;
                end else begin
                    n_status = ST_BAD_INDEX;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= w_probe;
            r_ridx  <= i_read_index;
        end
        if (w_fire) begin
            r_found   <= n_found;
            r_count_o <= IDX_W'(n_count);
            r_rval    <= n_rval;
            r_status  <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found_index = r_found;
    assign o_entry_count = r_count_o;
    assign o_read_value  = r_rval;
    assign o_status      = r_status;

endmodule

// ===== hw/rtl/sust_checker.sv =====
module sust_checker import sust_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [MODE_W-1:0]            i_mode,
    input logic signed [IN_VALUE_W-1:0] i_value,
    input logic [RIDX_W-1:0]            i_read_index,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [IDX_W-1:0]      o_found_index,
    input logic [IDX_W-1:0]             o_entry_count,
    input logic signed [IN_VALUE_W-1:0] o_read_value,
    input logic [STATUS_W-1:0]          o_status
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found_index) && $stable(o_status)
             && $stable(o_read_value) && $stable(o_entry_count)))
        else $error("result word changed before it was taken");

    // one word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous word still in work");

    // with the result register free, the word commits from S_EXEC without a stall and the reply follows
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |-> ##2 o_out_valid)
        else $error("result missing two cycles after accept");

    // every failing status reports the absent index
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_found_index == NO_INDEX))
        else $error("failure status with a valid index");

    // a nonzero read value only comes with a successful read
    a_read_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_value != '0) |-> (o_status == ST_DONE))
        else $error("read value set on a failed word");

endmodule

bind sorted_unique_set_table sust_checker u_sust_checker (.*);
